FILE: rtl/murmur64a_hash_defines.svh
// ----------------------------------------------------------------------------
// murmur64a_hash_defines.svh
// Assertion macros shared by the hash block. They expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MURMUR64A_HASH_DEFINES_SVH
`define MURMUR64A_HASH_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property with a reset qualifier.
`define MM64A_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);
// Checked property that also holds during reset.
`define MM64A_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MM64A_ASSERT(label, clk, rstn, prop, msg)
`define MM64A_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/mm64a_pkg.sv
// ----------------------------------------------------------------------------
// mm64a_pkg
// Types, constants and helper functions of the MurmurHash64A block.
// ----------------------------------------------------------------------------
package mm64a_pkg;

    // Mixing multiplier and its two halves.
    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'd3339675888;
    localparam logic [3:0]  FULL_BYTES = 4'd8;

    // Per-beat control carried down the front pipeline.
    typedef struct packed {
        logic fold;
        logic full;
        logic first;
        logic last;
    } ctl_t;

    // One classified beat handed from the front to the back.
    typedef struct packed {
        logic [63:0] k;
        logic [63:0] len_m;
        logic        fold;
        logic        first;
        logic        last;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_A,
        B_MUL_B,
        B_FIN_S,
        B_FIN_A,
        B_FIN_B
    } back_state_t;

    // Xor of a word with itself shifted right by the mixing shift.
    function automatic logic [63:0] xorshift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

FILE: rtl/mm64a_mul.sv
// ----------------------------------------------------------------------------
// mm64a_mul
// Two-stage multiplier by the mixing constant, modulo 2^64. The first stage
// forms three 32x32 partial products, the second adds them.
// ----------------------------------------------------------------------------
module mm64a_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] hl_reg;
    logic [31:0] lh_reg;
    logic [63:0] p_reg;

    // Partial products; only the low halves of the cross terms matter.
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= 64'(a[31:0]) * 64'(mm64a_pkg::MIX_MUL_LO);
            hl_reg <= 32'(a[63:32] * mm64a_pkg::MIX_MUL_LO);
            lh_reg <= 32'(a[31:0] * mm64a_pkg::MIX_MUL_HI);
        end
    end

    // Final sum of the partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= ll_reg + {hl_reg + lh_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/mm64a_front.sv
// ----------------------------------------------------------------------------
// mm64a_front
// Accepts input beats, masks and classifies them, mixes full words and forms
// the length product for the seed. Five-stage pipeline with a common stall.
// ----------------------------------------------------------------------------
module mm64a_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_msg_len,
    input  logic [63:0]         s_data_word,
    input  logic [3:0]          s_byte_count,
    input  logic                s_first,
    input  logic                s_last,
    output logic                q_push,
    output mm64a_pkg::entry_t   q_data,
    input  logic                q_full
);

    localparam int STAGES = 5;

    logic                v_reg [STAGES];
    mm64a_pkg::ctl_t     ctl_reg [STAGES];
    logic [63:0]         word_reg [STAGES];
    logic [31:0]         len_reg;
    logic [63:0]         lenm_reg [3:4];

    logic                adv;
    logic [3:0]          cnt;
    logic [63:0]         word_masked;
    mm64a_pkg::ctl_t     ctl_in;
    logic [63:0]         k1;
    logic [63:0]         k2;
    logic [63:0]         lenm;

    // The whole pipeline moves unless the oldest beat cannot enter the queue.
    assign adv     = !v_reg[STAGES-1] || !q_full;
    assign s_ready = adv;
    assign q_push  = v_reg[STAGES-1] && !q_full;

    // Clamp the byte count and zero the bytes above it.
    always_comb begin
        cnt = (s_byte_count > mm64a_pkg::FULL_BYTES) ? mm64a_pkg::FULL_BYTES
                                                     : s_byte_count;
        for (int i = 0; i < 8; i++) begin
            word_masked[8*i +: 8] = (4'(i) < cnt) ? s_data_word[8*i +: 8] : 8'd0;
        end
        ctl_in.fold  = (cnt != 4'd0);
        ctl_in.full  = (cnt == mm64a_pkg::FULL_BYTES);
        ctl_in.first = s_first;
        ctl_in.last  = s_last;
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < STAGES; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0]  <= ctl_in;
            word_reg[0] <= word_masked;
            len_reg     <= s_msg_len;
            for (int i = 1; i < STAGES; i++) begin
                ctl_reg[i]  <= ctl_reg[i-1];
                word_reg[i] <= word_reg[i-1];
            end
            lenm_reg[3] <= lenm;
            lenm_reg[4] <= lenm_reg[3];
        end
    end

    // First mixing multiply and the length product run side by side.
    mm64a_mul u_mul_word (
        .aclk (aclk),
        .en   (adv),
        .a    (word_reg[0]),
        .p    (k1)
    );

    mm64a_mul u_mul_len (
        .aclk (aclk),
        .en   (adv),
        .a    ({32'd0, len_reg}),
        .p    (lenm)
    );

    // Second mixing multiply after the xor-shift.
    mm64a_mul u_mul_mix (
        .aclk (aclk),
        .en   (adv),
        .a    (mm64a_pkg::xorshift(k1)),
        .p    (k2)
    );

    // Full words go out mixed, tail words as they came in.
    always_comb begin
        q_data.k     = ctl_reg[STAGES-1].full ? k2 : word_reg[STAGES-1];
        q_data.len_m = lenm_reg[4];
        q_data.fold  = ctl_reg[STAGES-1].fold;
        q_data.first = ctl_reg[STAGES-1].first;
        q_data.last  = ctl_reg[STAGES-1].last;
    end

endmodule

FILE: rtl/mm64a_fifo.sv
// ----------------------------------------------------------------------------
// mm64a_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module mm64a_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mm64a_pkg::entry_t   push_data,
    output logic                full,
    input  logic                pop,
    output mm64a_pkg::entry_t   pop_data,
    output logic                valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mm64a_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mm64a_back.sv
// ----------------------------------------------------------------------------
// mm64a_back
// Folds queued beats into the running hash, finalizes it on the last beat of
// a message and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "murmur64a_hash_defines.svh"

module mm64a_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data,
    input  logic                q_valid,
    input  mm64a_pkg::entry_t   q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_hash
);

    mm64a_pkg::back_state_t state_reg, state_next;
    logic [63:0]            seed_reg;
    logic [63:0]            running_reg, running_next;
    logic                   cur_last_reg, cur_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_hash_reg, out_hash_next;

    logic [63:0]            mul_a;
    logic [63:0]            mul_p;
    logic [63:0]            cur_h;
    logic [63:0]            start_h;

    // The seed register takes writes at any time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= mm64a_pkg::SEED_RESET;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    // A product that just finished is the hash the next beat continues from.
    assign cur_h   = (state_reg == mm64a_pkg::B_MUL_B) ? mul_p : running_reg;
    assign start_h = q_entry.first ? (seed_reg ^ q_entry.len_m) : cur_h;

    // Next state, queue pop, multiplier operand and output register.
    always_comb begin
        state_next     = state_reg;
        running_next   = running_reg;
        cur_last_next  = cur_last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_hash_next  = out_hash_reg;
        mul_a          = start_h ^ q_entry.k;
        q_pop          = 1'b0;
        unique case (state_reg) inside
            mm64a_pkg::B_IDLE, mm64a_pkg::B_MUL_B: begin
                if (state_reg == mm64a_pkg::B_MUL_B) begin
                    running_next = mul_p;
                    state_next   = cur_last_reg ? mm64a_pkg::B_FIN_S
                                                : mm64a_pkg::B_IDLE;
                end
                if (q_valid && !(state_reg == mm64a_pkg::B_MUL_B && cur_last_reg)) begin
                    q_pop         = 1'b1;
                    cur_last_next = q_entry.last;
                    if (q_entry.fold) begin
                        state_next = mm64a_pkg::B_MUL_A;
                    end else begin
                        running_next = start_h;
                        state_next   = q_entry.last ? mm64a_pkg::B_FIN_S
                                                    : mm64a_pkg::B_IDLE;
                    end
                end
            end
            mm64a_pkg::B_MUL_A: begin
                state_next = mm64a_pkg::B_MUL_B;
            end
            mm64a_pkg::B_FIN_S: begin
                mul_a = mm64a_pkg::xorshift(running_reg);
                if (!out_valid_reg) begin
                    state_next = mm64a_pkg::B_FIN_A;
                end
            end
            mm64a_pkg::B_FIN_A: begin
                state_next = mm64a_pkg::B_FIN_B;
            end
            mm64a_pkg::B_FIN_B: begin
                out_hash_next  = mm64a_pkg::xorshift(mul_p);
                out_valid_next = 1'b1;
                running_next   = '0;
                state_next     = mm64a_pkg::B_IDLE;
            end
            default: begin
                state_next = mm64a_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mm64a_pkg::B_IDLE;
            running_reg   <= '0;
            cur_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            cur_last_reg  <= cur_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_hash_reg <= out_hash_next;
    end

    // Shared multiplier for the fold and the finalization.
    mm64a_mul u_mul_hash (
        .aclk (aclk),
        .en   (1'b1),
        .a    (mul_a),
        .p    (mul_p)
    );

    assign m_valid = out_valid_reg;
    assign m_hash  = out_hash_reg;

    // A fold multiply in B_MUL_A always moves on to B_MUL_B.
    `MM64A_ASSERT(a_mul_timing, aclk, aresetn,
        (state_reg == mm64a_pkg::B_MUL_A) |=> (state_reg == mm64a_pkg::B_MUL_B),
        "fold multiply did not complete in order")
    // Finalization writes only into an empty output register.
    `MM64A_ASSERT(a_fin_free, aclk, aresetn,
        (state_reg == mm64a_pkg::B_FIN_B) |-> !out_valid_reg,
        "finalization overwrote a waiting result")
    // A new result always comes from the end of finalization, with a cleared hash.
    `MM64A_ASSERT(a_result_src, aclk, aresetn,
        $rose(out_valid_reg) |->
            ($past(state_reg == mm64a_pkg::B_FIN_B) && running_reg == 64'd0),
        "result appeared outside finalization")
    // The queue is popped only when the back can take a beat.
    `MM64A_ASSERT(a_pop_ok, aclk, aresetn,
        q_pop |-> (q_valid && (state_reg == mm64a_pkg::B_IDLE ||
            (state_reg == mm64a_pkg::B_MUL_B && !cur_last_reg))),
        "queue popped at a wrong time")

endmodule

FILE: rtl/murmur64a_hash.sv
// ----------------------------------------------------------------------------
// murmur64a_hash
// Streaming 64-bit MurmurHash64A of a byte message delivered as
// little-endian 64-bit words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   msg_len, data_word, byte_count,
//                                           first, last
//  m_        out        m_valid / m_ready   hash
//  cfg_      in         cfg_wr_en           cfg_wr_data (seed)
//
// The front pipeline takes one beat per cycle unless a full queue stalls it,
// and mixes each full word as it moves down the pipeline. The back folds beats
// through one two-stage multiplier, a folded beat in B_MUL_A and B_MUL_B,
// an empty beat without a multiply; after the last beat, finalization runs
// through B_FIN_S, B_FIN_A and B_FIN_B and registers the result. The hash
// feedback through that multiplier keeps a new word waiting for the last product.
// Reset is synchronous and clears all control state and sets the seed to its
// default. A stalled result stalls the back only at finalization; the queue
// then fills and the front stops taking beats.
// ----------------------------------------------------------------------------
module murmur64a_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_msg_len,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    mm64a_pkg::entry_t  q_in;
    mm64a_pkg::entry_t  q_out;

    // Classification and word mixing.
    mm64a_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_msg_len    (s_msg_len),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_first      (s_first),
        .s_last       (s_last),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_full       (q_full)
    );

    // Queue between the two halves.
    mm64a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    // Hash fold and finalization.
    mm64a_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash      (m_hash)
    );

endmodule
